// File: rtl/eyeh_pkg.sv
// Shared constants, codes and control types of the eye-diagram histogram.
package eyeh_pkg;

   localparam int IMAGE_WIDTH  = 128;
   localparam int IMAGE_HEIGHT = 64;
   localparam int OVERSAMPLE   = 16;
   localparam int SAMPLE_BITS  = 16;

   localparam int PERIOD    = 2 * OVERSAMPLE;
   localparam int PH_W      = $clog2(PERIOD);
   localparam int ROW_W     = $clog2(IMAGE_HEIGHT);
   localparam int COL_W     = $clog2(IMAGE_WIDTH);
   localparam int ADDR_W    = ROW_W + COL_W;
   localparam int DEPTH     = IMAGE_HEIGHT * IMAGE_WIDTH;
   localparam int COL_SCALE = IMAGE_WIDTH / PERIOD;

   // scan window round the centre of the first UI
   localparam int SCAN_CX   = IMAGE_WIDTH / 4;
   localparam int SCAN_HALF = (IMAGE_WIDTH / 32) > 0 ? IMAGE_WIDTH / 32 : 1;
   localparam int SCAN_X0   = SCAN_CX > SCAN_HALF ? SCAN_CX - SCAN_HALF : 0;
   localparam int SCAN_X1   = (SCAN_CX + SCAN_HALF) > (IMAGE_WIDTH - 1) ?
                              IMAGE_WIDTH - 1 : SCAN_CX + SCAN_HALF;
   localparam int SCAN_NX   = SCAN_X1 - SCAN_X0 + 1;
   localparam int SCAN_XW   = $clog2(SCAN_NX);

   localparam int MAX_RES   = 16;
   localparam int RUN_W     = 7;
   localparam int FOUND_W   = 5;
   localparam int RES_IDX_W = 4;

   // row = (2*d*(H-1) + span) / (2*span)
   localparam int ROW_MUL   = 2 * (IMAGE_HEIGHT - 1);
   localparam int NUM_W     = 24;
   localparam int DEN_W     = SAMPLE_BITS + 2;

   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;
   localparam logic [1:0] CMD_SCAN   = 2'd3;

   localparam logic [1:0] KIND_BIN     = 2'd0;
   localparam logic [1:0] KIND_OPENING = 2'd1;
   localparam logic [1:0] KIND_NONE    = 2'd2;

   localparam logic CSR_LOW  = 1'b0;
   localparam logic CSR_HIGH = 1'b1;

   typedef struct packed {
      logic accept;
      logic prep;
      logic div_step;
      logic samp_rd;
      logic samp_wr;
      logic clr_step;
      logic bin_rd;
      logic bin_emit;
      logic scan_rd;
      logic scan_ev;
      logic scan_fin;
      logic scan_emit;
   } eyeh_cmd_type;

   typedef struct packed {
      logic span_pos;
      logic div_done;
      logic clr_done;
      logic scan_stop;
      logic scan_done;
      logic emit_last;
      logic out_free;
   } eyeh_stat_type;

endpackage

// File: rtl/eyeh_ctrl.sv
// Controller state machine sequencing samples, reads, clears and scans.
module eyeh_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_cmd,
   output logic                   req_stall,
   input  eyeh_pkg::eyeh_stat_type stat,
   output eyeh_pkg::eyeh_cmd_type  cmd
);
   import eyeh_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_CLEAR = 4'd1;
   localparam logic [3:0] ST_PREP  = 4'd2;
   localparam logic [3:0] ST_DIV   = 4'd3;
   localparam logic [3:0] ST_SRD   = 4'd4;
   localparam logic [3:0] ST_SWR   = 4'd5;
   localparam logic [3:0] ST_RRD   = 4'd6;
   localparam logic [3:0] ST_REMIT = 4'd7;
   localparam logic [3:0] ST_SCHK  = 4'd8;
   localparam logic [3:0] ST_SCRD  = 4'd9;
   localparam logic [3:0] ST_SCEV  = 4'd10;
   localparam logic [3:0] ST_SCFIN = 4'd11;
   localparam logic [3:0] ST_EMIT  = 4'd12;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_cmd)
                  CMD_SAMPLE: state_in = ST_PREP;
                  CMD_READ:   state_in = ST_RRD;
                  CMD_CLEAR:  state_in = ST_CLEAR;
                  CMD_SCAN:   state_in = ST_SCHK;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_done) state_in = ST_IDLE;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = stat.span_pos ? ST_DIV : ST_IDLE;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = ST_SRD;
         end
         ST_SRD: begin
            cmd.samp_rd = 1'b1;
            state_in    = ST_SWR;
         end
         ST_SWR: begin
            cmd.samp_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_RRD: begin
            cmd.bin_rd = 1'b1;
            state_in   = ST_REMIT;
         end
         ST_REMIT: begin
            if (stat.out_free) begin
               cmd.bin_emit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_SCHK: begin
            state_in = stat.scan_stop ? ST_SCFIN : ST_SCRD;
         end
         ST_SCRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCEV;
         end
         ST_SCEV: begin
            cmd.scan_ev = 1'b1;
            state_in    = stat.scan_done ? ST_SCFIN : ST_SCRD;
         end
         ST_SCFIN: begin
            cmd.scan_fin = 1'b1;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.scan_emit = 1'b1;
               if (stat.emit_last) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // reset lands in the clearing sweep of the bin store
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/eyeh_dp.sv
// Datapath: level registers, phase tracking, row divider, bin store, scan and result register.
module eyeh_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [1:0]             req_cmd,
   input  logic signed [15:0]     req_sample,
   input  logic                   req_buffer_last,
   input  logic [15:0]            req_phase_offset,
   input  logic [5:0]             req_row,
   input  logic [6:0]             req_col,
   input  logic [4:0]             req_max_openings,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata,
   input  eyeh_pkg::eyeh_cmd_type  cmd,
   output eyeh_pkg::eyeh_stat_type stat,
   input  logic                   rsp_stall,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_kind,
   output logic [31:0]            rsp_bin_count,
   output logic [31:0]            rsp_total_hits,
   output logic [6:0]             rsp_opening_rows,
   output logic [15:0]            rsp_opening_height,
   output logic                   rsp_last
);
   import eyeh_pkg::*;

   logic signed [SAMPLE_BITS-1:0] low_ff, high_ff;
   logic [PH_W-1:0]    phase_ff, ph_ff;
   logic               start_ff;
   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic [ROW_W-1:0]   rrow_ff;
   logic [COL_W-1:0]   rcol_ff;
   logic [FOUND_W-1:0] maxo_ff;
   logic [31:0]        hit_ff;

   logic [NUM_W-1:0]   rem_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [ROW_W-1:0]   q_ff;
   logic [$clog2(ROW_W)-1:0] cnt_ff;

   logic [ADDR_W-1:0]  clr_addr_ff;
   logic [31:0]        mem [DEPTH];
   logic [31:0]        rd_ff;

   logic [ROW_W-1:0]   y_ff;
   logic [SCAN_XW-1:0] x_ff;
   logic               nz_ff;
   logic [RUN_W-1:0]   run_ff;
   logic [FOUND_W-1:0] found_ff;
   logic [RUN_W-1:0]   runs_ff [MAX_RES];
   logic [RES_IDX_W-1:0] k_ff;

   logic               rsp_valid_ff;
   logic [1:0]         kind_ff;
   logic [31:0]        bin_ff, tot_ff;
   logic [6:0]         orows_ff;
   logic [15:0]        oheight_ff;
   logic               last_ff;

   // level arithmetic
   logic signed [SAMPLE_BITS:0] span;
   logic signed [SAMPLE_BITS-1:0] s_cl;
   logic [SAMPLE_BITS:0] amp_diff;
   logic [NUM_W-1:0]   num;
   logic [PH_W-1:0]    ph_new;
   logic [NUM_W-1:0]   div_sh;
   logic [COL_W-1:0]   samp_col;
   logic [ADDR_W-1:0]  samp_addr;
   logic [ADDR_W-1:0]  rd_addr;
   logic               mem_rd, mem_we;
   logic [ADDR_W-1:0]  wr_addr;
   logic [31:0]        wr_data;
   logic [31:0]        bin_inc;
   logic               row_nz, x_last, store_run;
   logic [FOUND_W-1:0] found_next;
   logic [RUN_W-1:0]   cur_run;
   logic [NUM_W-1:0]   prod;
   logic [4:0]         maxo_cl;

   assign span = (SAMPLE_BITS+1)'(high_ff) - (SAMPLE_BITS+1)'(low_ff);

   always_comb begin
      if (sample_ff < low_ff) s_cl = low_ff;
      else if (sample_ff > high_ff) s_cl = high_ff;
      else s_cl = sample_ff;
   end

   assign amp_diff = (SAMPLE_BITS+1)'((SAMPLE_BITS+1)'(high_ff) - (SAMPLE_BITS+1)'(s_cl));
   assign num  = NUM_W'(NUM_W'(amp_diff) * NUM_W'(ROW_MUL)) + NUM_W'(span);
   assign ph_new = start_ff ? PH_W'(req_phase_offset % PERIOD) : phase_ff;
   assign div_sh = NUM_W'(den_ff) << cnt_ff;
   assign samp_col = COL_W'(ph_ff * COL_SCALE);
   assign samp_addr = {q_ff, samp_col};
   assign bin_inc = (rd_ff == 32'hFFFF_FFFF) ? rd_ff : rd_ff + 32'd1;
   assign maxo_cl = (req_max_openings > 5'(MAX_RES)) ? 5'(MAX_RES) : req_max_openings;

   // scan row evaluation
   assign row_nz     = nz_ff | (rd_ff != 32'd0);
   assign x_last     = (x_ff == SCAN_XW'(SCAN_NX - 1));
   assign store_run  = row_nz && (run_ff > RUN_W'(1));
   assign found_next = found_ff + FOUND_W'(store_run);
   assign cur_run    = runs_ff[k_ff];
   assign prod       = NUM_W'(cur_run) * NUM_W'(span[SAMPLE_BITS-1:0]);

   assign stat.span_pos  = (span > 0);
   assign stat.div_done  = (cnt_ff == '0);
   assign stat.clr_done  = &clr_addr_ff;
   assign stat.scan_stop = (found_ff >= maxo_ff);
   assign stat.scan_done = x_last && ((y_ff == ROW_W'(IMAGE_HEIGHT - 1)) ||
                                      (found_next >= maxo_ff));
   assign stat.emit_last = (found_ff == '0) || (FOUND_W'(k_ff) == found_ff - FOUND_W'(1));
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      mem_rd  = cmd.samp_rd | cmd.bin_rd | cmd.scan_rd;
      rd_addr = samp_addr;
      if (cmd.bin_rd) rd_addr = {rrow_ff, rcol_ff};
      else if (cmd.scan_rd) rd_addr = {y_ff, COL_W'(COL_W'(SCAN_X0) + COL_W'(x_ff))};
      mem_we  = cmd.clr_step | cmd.samp_wr;
      wr_addr = cmd.clr_step ? clr_addr_ff : samp_addr;
      wr_data = cmd.clr_step ? 32'd0 : bin_inc;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[wr_addr] <= wr_data;
      if (mem_rd) rd_ff <= mem[rd_addr];
   end

   // control and counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         high_ff      <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         phase_ff     <= '0;
         start_ff     <= 1'b1;
         hit_ff       <= '0;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_LOW:  low_ff  <= csr_wdata;
               CSR_HIGH: high_ff <= csr_wdata;
               default:  ;
            endcase
         end
         if (cmd.accept && req_cmd == CMD_SAMPLE) begin
            phase_ff <= PH_W'((ph_new + 1) % PERIOD);
            start_ff <= req_buffer_last;
         end
         if (cmd.accept && req_cmd == CMD_CLEAR) hit_ff <= '0;
         if (cmd.samp_wr && hit_ff != 32'hFFFF_FFFF) hit_ff <= hit_ff + 32'd1;
         if (cmd.clr_step) clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         if (cmd.bin_emit || cmd.scan_emit) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         sample_ff <= req_sample;
         rrow_ff   <= req_row;
         rcol_ff   <= req_col;
         maxo_ff   <= maxo_cl;
         ph_ff     <= ph_new;
         y_ff      <= '0;
         x_ff      <= '0;
         nz_ff     <= 1'b0;
         run_ff    <= '0;
         found_ff  <= '0;
      end
      if (cmd.prep) begin
         rem_ff <= num;
         den_ff <= DEN_W'({span, 1'b0});
         q_ff   <= '0;
         cnt_ff <= ($clog2(ROW_W))'(ROW_W - 1);
      end
      if (cmd.div_step) begin
         if (rem_ff >= div_sh) begin
            rem_ff       <= rem_ff - div_sh;
            q_ff[cnt_ff] <= 1'b1;
         end
         cnt_ff <= cnt_ff - 1'b1;
      end
      if (cmd.scan_ev) begin
         if (!x_last) begin
            nz_ff <= row_nz;
            x_ff  <= x_ff + SCAN_XW'(1);
         end else begin
            nz_ff <= 1'b0;
            x_ff  <= '0;
            y_ff  <= y_ff + ROW_W'(1);
            if (!row_nz) begin
               run_ff <= run_ff + RUN_W'(1);
            end else begin
               run_ff <= '0;
               if (store_run) begin
                  runs_ff[found_ff[RES_IDX_W-1:0]] <= run_ff;
                  found_ff <= found_next;
               end
            end
         end
      end
      if (cmd.scan_fin) begin
         k_ff <= '0;
         // a run still open at the bottom
         if (run_ff > RUN_W'(1) && found_ff < maxo_ff) begin
            runs_ff[found_ff[RES_IDX_W-1:0]] <= run_ff;
            found_ff <= found_ff + FOUND_W'(1);
         end
      end
      if (cmd.bin_emit) begin
         kind_ff    <= KIND_BIN;
         bin_ff     <= rd_ff;
         tot_ff     <= hit_ff;
         orows_ff   <= '0;
         oheight_ff <= '0;
         last_ff    <= 1'b1;
      end
      if (cmd.scan_emit) begin
         bin_ff  <= '0;
         tot_ff  <= hit_ff;
         last_ff <= stat.emit_last;
         k_ff    <= k_ff + RES_IDX_W'(1);
         if (found_ff == '0) begin
            kind_ff    <= KIND_NONE;
            orows_ff   <= '0;
            oheight_ff <= '0;
         end else begin
            kind_ff    <= KIND_OPENING;
            orows_ff   <= cur_run;
            oheight_ff <= stat.span_pos ? 16'(prod / IMAGE_HEIGHT) : 16'd0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_bin_count      = bin_ff;
   assign rsp_total_hits     = tot_ff;
   assign rsp_opening_rows   = orows_ff;
   assign rsp_opening_height = oheight_ff;
   assign rsp_last           = last_ff;

endmodule

// File: rtl/eye_diagram_histogram.sv
// Eye-diagram density histogram: top level joining controller and datapath.
// One command is taken at a time. A sample, when high is above low, runs level
// clamp and scaling, a six-step shift-subtract divider for the row, then a
// read and a write of the single-port bin store. A bin read reads the store,
// then waits for the result register. A scan reads 9 window bins per row over
// up to 64 rows, then reports its first result and one further opening per
// cycle while the result register is free.
// A clear, and reset, sweep all 8192 bins at one a cycle, during which no
// command is taken; the result register lets a new command in while the last
// result still waits on rsp_stall.
module eye_diagram_histogram (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_cmd,
   input  logic signed [15:0] req_sample,
   input  logic               req_buffer_last,
   input  logic [15:0]        req_phase_offset,
   input  logic [5:0]         req_row,
   input  logic [6:0]         req_col,
   input  logic [4:0]         req_max_openings,
   input  logic               csr_write_enable,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic [31:0]        rsp_bin_count,
   output logic [31:0]        rsp_total_hits,
   output logic [6:0]         rsp_opening_rows,
   output logic [15:0]        rsp_opening_height,
   output logic               rsp_last
);
   import eyeh_pkg::*;

   eyeh_cmd_type  cmd;
   eyeh_stat_type stat;

   eyeh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   eyeh_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_cmd            (req_cmd),
      .req_sample         (req_sample),
      .req_buffer_last    (req_buffer_last),
      .req_phase_offset   (req_phase_offset),
      .req_row            (req_row),
      .req_col            (req_col),
      .req_max_openings   (req_max_openings),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_kind           (rsp_kind),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_total_hits     (rsp_total_hits),
      .rsp_opening_rows   (rsp_opening_rows),
      .rsp_opening_height (rsp_opening_height),
      .rsp_last           (rsp_last)
   );

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the eye-diagram density histogram.
module testbench;
   import eyeh_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 40000;
   localparam int SETTLE_WAIT = 8400;  // longest silent work: a clear sweep
   localparam int DRAIN_WAIT  = 1300;  // longest scan

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] bin_count;
      logic [31:0] total_hits;
      logic [6:0]  rows;
      logic [15:0] height;
      logic        last;
   } eye_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = CMD_READ;
   logic signed [15:0] req_sample = '0;
   logic req_buffer_last = 1'b0;
   logic [15:0] req_phase_offset = '0;
   logic [5:0] req_row = '0;
   logic [6:0] req_col = '0;
   logic [4:0] req_max_openings = '0;
   logic csr_write_enable = 1'b0;
   logic csr_index = CSR_LOW;
   logic [15:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [31:0] rsp_bin_count;
   logic [31:0] rsp_total_hits;
   logic [6:0] rsp_opening_rows;
   logic [15:0] rsp_opening_height;
   logic rsp_last;

   eye_diagram_histogram u_dut (.*);

   always #4 clock = ~clock;

   // histogram image and counters as the block should hold them
   bit [31:0] bin_image [DEPTH];
   bit [31:0] hit_count = 0;
   int phase_now = 0;
   bit buf_start = 1'b1;
   logic signed [15:0] lvl_low = -16'sd32768;
   logic signed [15:0] lvl_high = 16'sd32767;
   eye_result_type result_q[$];

   int errors = 0;
   int burst_left = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      $display("MISMATCH %s: expected %0d, got %0d at %0t", what, exp_v, got_v, $realtime);
      errors++;
   endtask

   function automatic void push_result(logic [1:0] kind, logic [31:0] bin, logic [6:0] rows,
                                       logic [15:0] height, logic last);
      eye_result_type r;
      r.kind = kind; r.bin_count = bin; r.total_hits = hit_count;
      r.rows = rows; r.height = height; r.last = last;
      result_q.push_back(r);
   endfunction

   function automatic void histogram_update(logic [1:0] cmd, logic signed [15:0] smp,
                                            logic blast, logic [15:0] poff, logic [5:0] row,
                                            logic [6:0] col, logic [4:0] maxo_in);
      longint lo, hi, span, s, d, r, c;
      int ph, half, x0, x1, maxo, found, run;
      bit empty;
      int runs [MAX_RES];
      lo = lvl_low; hi = lvl_high; span = hi - lo;
      case (cmd)
         CMD_SAMPLE: begin
            ph = buf_start ? int'(poff) % PERIOD : phase_now;
            if (span > 0) begin
               s = smp;
               if (s < lo) s = lo;
               if (s > hi) s = hi;
               d = hi - s;
               r = (2 * d * (IMAGE_HEIGHT - 1) + span) / (2 * span);
               if (r >= IMAGE_HEIGHT) r = IMAGE_HEIGHT - 1;
               c = longint'(ph) * IMAGE_WIDTH / PERIOD;
               if (c >= IMAGE_WIDTH) c = IMAGE_WIDTH - 1;
               if (bin_image[r * IMAGE_WIDTH + c] != 32'hFFFF_FFFF)
                  bin_image[r * IMAGE_WIDTH + c]++;
               if (hit_count != 32'hFFFF_FFFF) hit_count++;
            end
            phase_now = (ph + 1) % PERIOD;
            buf_start = blast;
         end
         CMD_READ: begin
            push_result(KIND_BIN, bin_image[int'(row) * IMAGE_WIDTH + int'(col)], '0, '0, 1'b1);
         end
         CMD_CLEAR: begin
            foreach (bin_image[i]) bin_image[i] = 0;
            hit_count = 0;
         end
         default: begin
            half = (IMAGE_WIDTH / 32) > 0 ? IMAGE_WIDTH / 32 : 1;
            x0 = (IMAGE_WIDTH / 4) > half ? IMAGE_WIDTH / 4 - half : 0;
            x1 = IMAGE_WIDTH / 4 + half;
            if (x1 > IMAGE_WIDTH - 1) x1 = IMAGE_WIDTH - 1;
            maxo = maxo_in > MAX_RES ? MAX_RES : int'(maxo_in);
            found = 0; run = 0;
            for (int y = 0; y < IMAGE_HEIGHT && found < maxo; y++) begin
               empty = 1'b1;
               for (int x = x0; x <= x1; x++)
                  if (bin_image[y * IMAGE_WIDTH + x] != 0) empty = 1'b0;
               if (empty) run++;
               else begin
                  if (run > 1) runs[found++] = run;
                  run = 0;
               end
            end
            if (run > 1 && found < maxo) runs[found++] = run;
            if (found == 0) push_result(KIND_NONE, '0, '0, '0, 1'b1);
            for (int k = 0; k < found; k++)
               push_result(KIND_OPENING, '0, 7'(runs[k]),
                           16'(span > 0 ? (longint'(runs[k]) * span / IMAGE_HEIGHT) : 0),
                           k + 1 == found);
         end
      endcase
   endfunction

   // one transfer on the request side; valid stays high after acceptance
   task automatic send_item(logic [1:0] cmd, logic signed [15:0] smp, logic blast,
                            logic [15:0] poff, logic [5:0] row, logic [6:0] col,
                            logic [4:0] maxo);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      burst_left--;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd; req_sample <= smp; req_buffer_last <= blast;
      req_phase_offset <= poff; req_row <= row; req_col <= col; req_max_openings <= maxo;
      do @(posedge clock); while (req_stall);
      histogram_update(cmd, smp, blast, poff, row, col, maxo);
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   task automatic send_sample(logic signed [15:0] smp, logic blast, logic [15:0] poff);
      send_item(CMD_SAMPLE, smp, blast, poff, 6'($urandom), 7'($urandom), 5'($urandom));
   endtask

   task automatic send_read(logic [5:0] row, logic [6:0] col);
      send_item(CMD_READ, 16'($urandom), 1'($urandom), 16'($urandom), row, col,
                5'($urandom));
   endtask

   task automatic send_scan(logic [4:0] maxo);
      send_item(CMD_SCAN, 16'($urandom), 1'($urandom), 16'($urandom), 6'($urandom),
                7'($urandom), maxo);
   endtask

   task automatic send_clear();
      send_item(CMD_CLEAR, 16'($urandom), 1'($urandom), 16'($urandom), 6'($urandom),
                7'($urandom), 5'($urandom));
   endtask

   task automatic write_reg(logic idx, logic [15:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1; csr_index <= idx; csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_LOW) lvl_low = value;
      else lvl_high = value;
   endtask

   // only reprogram once the block has gone quiet
   task automatic set_levels(logic signed [15:0] lo, logic signed [15:0] hi);
      drop_valid();
      while (result_q.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      write_reg(CSR_LOW, lo);
      write_reg(CSR_HIGH, hi);
   endtask

   // two-level signal with noise, some transitions and some wild values
   function automatic logic signed [15:0] eye_value();
      longint span, base, noise, v;
      span = longint'(lvl_high) - longint'(lvl_low);
      if (span <= 0 || $urandom_range(99) < 15) return 16'($urandom);
      base = $urandom_range(1) ? longint'(lvl_high) : longint'(lvl_low);
      if ($urandom_range(99) < 10) base = lvl_low + longint'($urandom) % (span + 1);
      noise = span / 16 + 1;
      v = base + longint'($urandom_range(0, 2 * noise)) - noise;
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   task automatic test_extremes();
      send_sample(16'sd32767, 1'b1, 16'hFFFF);
      send_sample(-16'sd32768, 1'b0, 16'h0000);
      send_sample(16'sd0, 1'b0, 16'hFFFF);
      send_sample(16'sd0, 1'b1, 16'h5555);
      send_read(6'd0, 7'd124);
      send_read(6'd63, 7'd0);
      send_read(6'd31, 7'd4);
      send_read(6'd63, 7'd127);
      send_scan(5'd0);
      send_scan(5'd16);
      send_scan(5'd31);
      drop_valid();
   endtask

   task automatic test_clear();
      send_clear();
      send_read(6'd31, 7'd4);
      send_scan(5'd1);
      drop_valid();
   endtask

   // high not above low: nothing counted, phase still moves
   task automatic test_flat_levels();
      set_levels(16'sd5, 16'sd5);
      send_sample(16'sd5, 1'b1, 16'd8);
      send_sample(16'sd100, 1'b0, 16'd8);
      send_scan(5'd16);
      set_levels(16'sd100, -16'sd100);
      send_sample(16'sd0, 1'b1, 16'd9);
      send_read(6'd32, 7'd36);
      send_scan(5'd4);
      drop_valid();
   endtask

   task automatic test_random(int n_items, logic signed [15:0] lo, logic signed [15:0] hi);
      int count, len, pick;
      logic [15:0] poff;
      bit cleared;
      set_levels(lo, hi);
      count = 0; cleared = 0;
      while (count < n_items) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            len = $urandom_range(1, 24);
            if (len > n_items - count) len = n_items - count;
            poff = 16'($urandom);
            for (int k = 0; k < len; k++)
               send_sample(eye_value(), k == len - 1, k == 0 ? poff : 16'($urandom));
            count += len;
         end else if (pick < 82) begin
            if ($urandom_range(1)) send_read(6'($urandom), 7'($urandom));
            else send_read(6'($urandom), 7'($urandom_range(7, 9) * 4));
            count++;
         end else if (pick < 97 || cleared) begin
            send_scan($urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(1, 16)));
            count++;
         end else begin
            send_clear();
            cleared = 1;
            count++;
         end
      end
      drop_valid();
   endtask

   // receiver sits on its results while requests keep coming
   task automatic test_backpressure();
      hold_left = 600;
      for (int k = 0; k < 10; k++) begin
         if (k % 4 == 3) send_scan(5'($urandom_range(1, 16)));
         else send_read(6'($urandom), 7'($urandom));
      end
      drop_valid();
   endtask

   initial begin
      int seg_left, stall_pct;
      seg_left = 0; stall_pct = 0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(1, 60);
               case ($urandom_range(3))
                  0: stall_pct = 0;
                  1: stall_pct = 25;
                  2: stall_pct = 60;
                  default: stall_pct = 90;
               endcase
            end
            seg_left--;
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_results
      eye_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (result_q.size() == 0) begin
            report_mismatch("unexpected result, kind", -1, rsp_kind);
         end else begin
            exp_r = result_q.pop_front();
            if (rsp_kind !== exp_r.kind) report_mismatch("kind", exp_r.kind, rsp_kind);
            if (rsp_bin_count !== exp_r.bin_count)
               report_mismatch("bin_count", exp_r.bin_count, rsp_bin_count);
            if (rsp_total_hits !== exp_r.total_hits)
               report_mismatch("total_hits", exp_r.total_hits, rsp_total_hits);
            if (rsp_opening_rows !== exp_r.rows)
               report_mismatch("opening_rows", exp_r.rows, rsp_opening_rows);
            if (rsp_opening_height !== exp_r.height)
               report_mismatch("opening_height", exp_r.height, rsp_opening_height);
            if (rsp_last !== exp_r.last) report_mismatch("last", exp_r.last, rsp_last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_clear();
      test_flat_levels();
      test_random(130, -16'sd32768, 16'sd32767);
      test_random(110, -16'sd1000, 16'sd1000);
      test_random(60, 16'sd0, 16'sd1);
      test_random(60, -16'sd32768, -16'sd32767);
      test_random(30, 16'sd300, -16'sd300);
      test_backpressure();
      while (result_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule

// File: sim.f
rtl/eyeh_pkg.sv
rtl/eyeh_ctrl.sv
rtl/eyeh_dp.sv
rtl/eye_diagram_histogram.sv
verif/testbench.sv
